@@ src/tlpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpc_pkg
// Shared types and constants for the traffic light pedestrian controller.
// ----------------------------------------------------------------------------
package tlpc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 5;
    localparam int REG_IDX_W       = 3;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 16;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_MAIN_GREEN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAIN_YELLOW = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIDE_GREEN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIDE_YELLOW = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WALK        = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BLINK       = 3'd5;

    // Reset values of the timing registers
    localparam logic [CFG_WIDTH-1:0] RST_MAIN_GREEN  = 16'd30;
    localparam logic [CFG_WIDTH-1:0] RST_MAIN_YELLOW = 16'd5;
    localparam logic [CFG_WIDTH-1:0] RST_SIDE_GREEN  = 16'd20;
    localparam logic [CFG_WIDTH-1:0] RST_SIDE_YELLOW = 16'd5;
    localparam logic [CFG_WIDTH-1:0] RST_WALK        = 16'd15;
    localparam logic [CFG_WIDTH-1:0] RST_BLINK       = 16'd5;

    typedef enum logic [2:0] {
        PH_MAIN_GREEN  = 3'd0,
        PH_MAIN_YELLOW = 3'd1,
        PH_WALK        = 3'd2,
        PH_BLINK       = 3'd3,
        PH_SIDE_GREEN  = 3'd4,
        PH_SIDE_YELLOW = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        LAMP_GREEN  = 2'd0,
        LAMP_YELLOW = 2'd1,
        LAMP_RED    = 2'd2
    } lamp_t;

    typedef enum logic [1:0] {
        PED_RED    = 2'd0,
        PED_STEADY = 2'd1,
        PED_BLINK  = 2'd2
    } ped_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] main_green_ticks;
        logic [CFG_WIDTH-1:0] main_yellow_ticks;
        logic [CFG_WIDTH-1:0] side_green_ticks;
        logic [CFG_WIDTH-1:0] side_yellow_ticks;
        logic [CFG_WIDTH-1:0] walk_ticks;
        logic [CFG_WIDTH-1:0] blink_ticks;
    } cfg_t;

    typedef struct packed {
        logic       request_pending;
        ped_t       walk_light;
        lamp_t      side_light;
        lamp_t      main_light;
        logic [2:0] phase;
    } result_t;

endpackage

@@ src/tlpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tlpc_cfg_regs
// APB register file holding the six phase durations.
// ----------------------------------------------------------------------------
module tlpc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlpc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tlpc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tlpc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output tlpc_pkg::cfg_t                    cfg
);
    import tlpc_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;
    logic [CFG_WIDTH-1:0] wval;
    logic [CFG_WIDTH-1:0] rval;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign wval   = pwdata[CFG_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.main_green_ticks  <= RST_MAIN_GREEN;
            cfg_reg.main_yellow_ticks <= RST_MAIN_YELLOW;
            cfg_reg.side_green_ticks  <= RST_SIDE_GREEN;
            cfg_reg.side_yellow_ticks <= RST_SIDE_YELLOW;
            cfg_reg.walk_ticks        <= RST_WALK;
            cfg_reg.blink_ticks       <= RST_BLINK;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MAIN_GREEN:  cfg_reg.main_green_ticks  <= wval;
                REG_MAIN_YELLOW: cfg_reg.main_yellow_ticks <= wval;
                REG_SIDE_GREEN:  cfg_reg.side_green_ticks  <= wval;
                REG_SIDE_YELLOW: cfg_reg.side_yellow_ticks <= wval;
                REG_WALK:        cfg_reg.walk_ticks        <= wval;
                REG_BLINK:       cfg_reg.blink_ticks       <= wval;
                default:         ;  // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MAIN_GREEN:  rval = cfg_reg.main_green_ticks;
            REG_MAIN_YELLOW: rval = cfg_reg.main_yellow_ticks;
            REG_SIDE_GREEN:  rval = cfg_reg.side_green_ticks;
            REG_SIDE_YELLOW: rval = cfg_reg.side_yellow_ticks;
            REG_WALK:        rval = cfg_reg.walk_ticks;
            REG_BLINK:       rval = cfg_reg.blink_ticks;
            default:         rval = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(rval);
    assign cfg    = cfg_reg;

endmodule

@@ src/tlpc_phase_fsm.sv @@
// ----------------------------------------------------------------------------
// tlpc_phase_fsm
// Phase state, green/yellow tick counters and request latch; one tick per en.
// ----------------------------------------------------------------------------
module tlpc_phase_fsm #(
    parameter int COUNT_WIDTH = tlpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              button_press,
    input  tlpc_pkg::cfg_t    cfg,
    output tlpc_pkg::result_t res
);
    import tlpc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] green_reg, green_next;
    logic [COUNT_WIDTH-1:0] yellow_reg, yellow_next;
    logic                   req_reg, req_next;
    logic                   req_set;
    logic [CFG_WIDTH-1:0]   g_lim, y_lim;
    logic                   g_exp, y_exp;

    // phase over once counter reaches limit, or counter saturated
    function automatic logic expired(input logic [COUNT_WIDTH-1:0] cnt,
                                     input logic [CFG_WIDTH-1:0]   lim);
        return (CMP_W'(cnt) >= CMP_W'(lim)) || (&cnt);
    endfunction

    always_comb
    begin
        case (phase_reg)
            PH_WALK:       g_lim = cfg.walk_ticks;
            PH_SIDE_GREEN: g_lim = cfg.side_green_ticks;
            default:       g_lim = cfg.main_green_ticks;
        endcase
        case (phase_reg)
            PH_BLINK:       y_lim = cfg.blink_ticks;
            PH_SIDE_YELLOW: y_lim = cfg.side_yellow_ticks;
            default:        y_lim = cfg.main_yellow_ticks;
        endcase
    end

    assign g_exp   = expired(green_reg, g_lim);
    assign y_exp   = expired(yellow_reg, y_lim);
    assign req_set = req_reg | button_press;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        green_next  = green_reg + CNT_ONE;
        yellow_next = yellow_reg;
        req_next    = req_set;
        case (phase_reg)
            PH_MAIN_GREEN:
            begin
                if (req_set || g_exp)
                begin
                    green_next = CNT_ONE;
                    phase_next = PH_MAIN_YELLOW;
                end
            end
            PH_MAIN_YELLOW:
            begin
                green_next  = green_reg;
                yellow_next = y_exp ? CNT_ONE : yellow_reg + CNT_ONE;
                if (y_exp)
                begin
                    if (req_set)
                    begin
                        req_next   = 1'b0;
                        phase_next = PH_WALK;
                    end
                    else
                    begin
                        phase_next = PH_SIDE_GREEN;
                    end
                end
            end
            PH_WALK, PH_SIDE_GREEN:
            begin
                if (g_exp)
                begin
                    green_next = CNT_ONE;
                    if (phase_reg == PH_WALK)
                        phase_next = PH_BLINK;
                    else
                        phase_next = PH_SIDE_YELLOW;
                end
            end
            PH_BLINK, PH_SIDE_YELLOW:
            begin
                green_next  = green_reg;
                yellow_next = y_exp ? CNT_ONE : yellow_reg + CNT_ONE;
                if (y_exp)
                    phase_next = PH_MAIN_GREEN;
            end
            default:
            begin
                // undefined code: hold phase and counters
                green_next = green_reg;
            end
        endcase
    end

    // outputs: lamps for the phase after this tick
    always_comb
    begin
        res.phase           = phase_next;
        res.request_pending = req_next;
        res.main_light      = LAMP_RED;
        res.side_light      = LAMP_RED;
        res.walk_light      = PED_RED;
        case (phase_next)
            PH_MAIN_GREEN:  res.main_light = LAMP_GREEN;
            PH_MAIN_YELLOW: res.main_light = LAMP_YELLOW;
            PH_WALK:
            begin
                res.side_light = LAMP_GREEN;
                res.walk_light = PED_STEADY;
            end
            PH_BLINK:
            begin
                res.side_light = LAMP_YELLOW;
                res.walk_light = PED_BLINK;
            end
            PH_SIDE_GREEN:  res.side_light = LAMP_GREEN;
            PH_SIDE_YELLOW: res.side_light = LAMP_YELLOW;
            default:        ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAIN_GREEN;
            green_reg  <= CNT_ONE;
            yellow_reg <= CNT_ONE;
            req_reg    <= 1'b0;
        end
        else if (en)
        begin
            phase_reg  <= phase_next;
            green_reg  <= green_next;
            yellow_reg <= yellow_next;
            req_reg    <= req_next;
        end
    end

endmodule

@@ src/traffic_light_pedestrian_controller.sv @@
// ----------------------------------------------------------------------------
// traffic_light_pedestrian_controller
// Six-phase intersection controller with latched pedestrian request.
// ----------------------------------------------------------------------------
// A tick passes the input register, then the result register, before its result is valid.
// Throughput: one tick per cycle while the result stream does not stall; the phase step is a single registered pass.
// Reset (rst_n, async low): main green, both counters at 1, no request,
//   durations back to 30/5/20/5/15/5, both pipeline registers empty.
// ----------------------------------------------------------------------------
module traffic_light_pedestrian_controller #(
    parameter int COUNT_WIDTH = tlpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tick stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tlpc_pkg::IN_TDATA_W-1:0]   s_tdata,   // [0] button_press
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tlpc_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [2:0] phase, [4:3] main_light,
                                                         // [6:5] side_light,
                                                         // [8:7] walk_light,
                                                         // [9] request_pending
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlpc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tlpc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tlpc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import tlpc_pkg::*;

    cfg_t    cfg;
    result_t res;

    // Input register: holds one accepted tick until the result slot is free.
    logic    in_valid_reg;
    logic    in_btn_reg;
    // Result register: decouples the FSM from a stalled consumer.
    logic    out_valid_reg;
    result_t out_reg;

    logic    advance;   // tick in input reg moves into result reg this cycle

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_btn_reg <= s_tdata[0];
    end

    // State moves only when the tick's result is captured, so a stall
    // never double-steps the phase machine.
    tlpc_phase_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .button_press (in_btn_reg),
        .cfg          (cfg),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_reg);

    tlpc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

`ifndef SYNTH
    // a held tick stays until its result slot opens
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input tick dropped while stalled");

    // main and side road never both non-red
    a_cross_safe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.main_light == LAMP_RED ||
                           out_reg.side_light == LAMP_RED))
        else $error("main and side both open");

    // pedestrians only walk while main road is red
    a_walk_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.walk_light != PED_RED) |->
            (out_reg.main_light == LAMP_RED))
        else $error("walk lamp lit with main road open");

    // a stalled result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result changed under stall");
`endif

endmodule
